// File: src/ssbi_pkg.sv
package ssbi_pkg;

  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 96;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 12;
  localparam int ROW_IDX_W    = 6;
  localparam int ROW_BITS_W   = 32;
  localparam int DRAW_W       = 7;
  localparam int COORD_W      = 12;
  localparam int SCREEN_ROW_W = 13;
  localparam int MASK_W       = 64;
  localparam int ON_W         = 4;

  localparam logic [DRAW_W-1:0] DRAW_RESET = 7'd32;
  localparam logic [ON_W-1:0]   THR_LARGE  = 4'd5;
  localparam logic [ON_W-1:0]   THR_SMALL  = 4'd4;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DRAW_SIZE = 2'd0,
    REG_ORIGIN_X  = 2'd1,
    REG_ORIGIN_Y  = 2'd2
  } reg_idx_t;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DIV_STEP = 7'b0000010,
    S_DIV_ROW  = 7'b0000100,
    S_ROWS     = 7'b0001000,
    S_DIV_COL  = 7'b0010000,
    S_COLS     = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

endpackage

// File: src/ssbi_ram.sv
module ssbi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: src/supersampled_bitmap_icon_scaler.sv
// load request: no result
// render request: three passes of the shared restoring divider (NW = numerator
// width, 14 at default parameters), a fetch of three icon rows, then one sub-sample
// column per cycle through the step unit for each of D (effective draw size) columns
// ready only in idle; rst_n (synchronous) resets control and config; icon rows undefined
module supersampled_bitmap_icon_scaler #(
  parameter int SRC_SIZE = 32,
  parameter int MAX_DRAW = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // row_index [5:0], row_bits [37:6], zero pad
  input  logic [ssbi_pkg::IN_TDATA_W-1:0]    in_tdata,
  // opcode
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // screen_row [12:0], screen_col_first [24:13], pixel_mask [88:25], zero pad
  output logic [ssbi_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_we,
  input  logic [ssbi_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [ssbi_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ssbi_pkg::*;

  localparam int AW = $clog2(SRC_SIZE);
  localparam int CW = AW + 1;
  localparam int DW = $clog2(MAX_DRAW + 1);
  localparam int VW = $clog2(6 * MAX_DRAW + 1);
  localparam int NW = $clog2(6 * MAX_DRAW * SRC_SIZE);
  localparam int KW = $clog2(NW);
  localparam int PAD_W = OUT_TDATA_W - SCREEN_ROW_W - COORD_W - MASK_W;

  state_t state_r, state_nxt;

  logic [DRAW_W-1:0]    draw_size_r, draw_size_nxt;
  logic [COORD_W-1:0]   origin_x_r, origin_x_nxt;
  logic [COORD_W-1:0]   origin_y_r, origin_y_nxt;

  logic [DW-1:0]        d_r, d_nxt;
  logic [VW-1:0]        dv_r, dv_nxt;
  logic [ON_W-1:0]      thr_r, thr_nxt;
  logic [ROW_IDX_W-1:0] y_r, y_nxt;

  logic [NW-1:0]        num_r, num_nxt;
  logic [VW-1:0]        rem_r, rem_nxt;
  logic [KW-1:0]        dcnt_r, dcnt_nxt;

  logic [CW-1:0]        q_r, q_nxt;
  logic [VW-1:0]        r_r, r_nxt;
  logic [CW-1:0]        qs_r, qs_nxt;
  logic [VW-1:0]        rs_r, rs_nxt;

  logic [1:0]           sidx_r, sidx_nxt;
  logic [ON_W-1:0]      on_r, on_nxt;
  logic [DW-1:0]        x_r, x_nxt;
  logic [MAX_DRAW-1:0]  mask_r, mask_nxt;
  logic [ROW_BITS_W-1:0] rows_r [3];
  logic [ROW_BITS_W-1:0] rows_nxt [3];

  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // input fields
  logic [ROW_IDX_W-1:0]  in_row;
  logic [ROW_BITS_W-1:0] in_bits;
  logic                  in_acc;
  logic [DW-1:0]         d_eff;

  // ram
  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [ROW_BITS_W-1:0] ram_rdata;

  // divider datapath
  logic [VW:0]           div_sh;
  logic                  div_ge;
  logic [VW-1:0]         div_rem;
  logic [NW-1:0]         div_quo;
  logic                  div_last;

  // step unit
  logic [VW:0]           stp_sum;
  logic                  stp_ge;
  logic [AW-1:0]         coord;
  logic [6:0]            coord7;
  logic [1:0]            col_cnt;
  logic [ON_W-1:0]       on_tot;

  logic [NW-1:0]         num_row;

  assign in_row  = in_tdata[ROW_IDX_W-1:0];
  assign in_bits = in_tdata[ROW_IDX_W +: ROW_BITS_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc  = in_tvalid && in_tready;

  always_comb begin
    if (draw_size_r == '0) begin
      d_eff = DW'(1);
    end else if (draw_size_r > DRAW_W'(MAX_DRAW)) begin
      d_eff = DW'(MAX_DRAW);
    end else begin
      d_eff = DW'(draw_size_r);
    end
  end

  assign ram_we = in_acc && (in_tuser == OP_LOAD) &&
                  ({1'b0, in_row} < (ROW_IDX_W + 1)'(SRC_SIZE));

  ssbi_ram #(
    .WIDTH(ROW_BITS_W),
    .DEPTH(SRC_SIZE)
  ) u_icon_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_row[AW-1:0]),
    .wdata (in_bits),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // restoring divider, one quotient bit per cycle
  assign div_sh   = {rem_r, num_r[NW-1]};
  assign div_ge   = div_sh >= {1'b0, dv_r};
  assign div_rem  = div_ge ? VW'(div_sh - {1'b0, dv_r}) : VW'(div_sh);
  assign div_quo  = {num_r[NW-2:0], div_ge};
  assign div_last = (dcnt_r == KW'(NW - 1));

  // walk to the next sub-sample: add quotient/remainder step, one wrap at most
  assign stp_sum = {1'b0, r_r} + {1'b0, rs_r};
  assign stp_ge  = stp_sum >= {1'b0, dv_r};

  assign coord     = (q_r > CW'(SRC_SIZE - 1)) ? AW'(SRC_SIZE - 1) : q_r[AW-1:0];
  assign coord7    = 7'(coord);
  assign ram_raddr = coord;

  always_comb begin
    logic b0, b1, b2;
    b0 = 1'b0;
    b1 = 1'b0;
    b2 = 1'b0;
    // source columns past the stored row width read as off
    if (coord7 < 7'd32) begin
      b0 = rows_r[0][coord7[4:0]];
      b1 = rows_r[1][coord7[4:0]];
      b2 = rows_r[2][coord7[4:0]];
    end
    col_cnt = 2'({1'b0, b0} + {1'b0, b1} + {1'b0, b2});
  end

  assign on_tot  = on_r + ON_W'(col_cnt);
  assign num_row = NW'((NW'(y_r) * NW'(6) + NW'(1)) * NW'(SRC_SIZE));

  always_comb begin
    state_nxt     = state_r;
    draw_size_nxt = draw_size_r;
    origin_x_nxt  = origin_x_r;
    origin_y_nxt  = origin_y_r;
    d_nxt         = d_r;
    dv_nxt        = dv_r;
    thr_nxt       = thr_r;
    y_nxt         = y_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    q_nxt         = q_r;
    r_nxt         = r_r;
    qs_nxt        = qs_r;
    rs_nxt        = rs_r;
    sidx_nxt      = sidx_r;
    on_nxt        = on_r;
    x_nxt         = x_r;
    mask_nxt      = mask_r;
    rows_nxt      = rows_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_addr)
        REG_DRAW_SIZE: draw_size_nxt = cfg_wdata[DRAW_W-1:0];
        REG_ORIGIN_X:  origin_x_nxt  = cfg_wdata[COORD_W-1:0];
        REG_ORIGIN_Y:  origin_y_nxt  = cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end

    // common divider and step-unit updates
    if (state_r == S_DIV_STEP || state_r == S_DIV_ROW || state_r == S_DIV_COL) begin
      num_nxt  = div_quo;
      rem_nxt  = div_rem;
      dcnt_nxt = dcnt_r + KW'(1);
    end
    if (state_r == S_ROWS || state_r == S_COLS) begin
      q_nxt = q_r + qs_r + CW'(stp_ge);
      r_nxt = stp_ge ? VW'(stp_sum - {1'b0, dv_r}) : VW'(stp_sum);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_tuser == OP_RENDER && {1'b0, in_row} < 7'(d_eff)) begin
          d_nxt    = d_eff;
          dv_nxt   = VW'(VW'(d_eff) * VW'(6));
          thr_nxt  = (DRAW_W'(d_eff) >= DRAW_W'(SRC_SIZE)) ? THR_LARGE : THR_SMALL;
          y_nxt    = in_row;
          mask_nxt = '0;
          num_nxt  = NW'(2 * SRC_SIZE);
          rem_nxt  = '0;
          dcnt_nxt = '0;
          state_nxt = S_DIV_STEP;
        end
      end
      S_DIV_STEP: begin
        if (div_last) begin
          qs_nxt   = CW'(div_quo);
          rs_nxt   = div_rem;
          num_nxt  = num_row;
          rem_nxt  = '0;
          dcnt_nxt = '0;
          state_nxt = S_DIV_ROW;
        end
      end
      S_DIV_ROW: begin
        if (div_last) begin
          q_nxt    = CW'(div_quo);
          r_nxt    = div_rem;
          sidx_nxt = '0;
          state_nxt = S_ROWS;
        end
      end
      S_ROWS: begin
        // read issued this cycle lands in the next one; row order does not matter
        if (sidx_r != 2'd0) begin
          rows_nxt[0] = ram_rdata;
          rows_nxt[1] = rows_r[0];
          rows_nxt[2] = rows_r[1];
        end
        sidx_nxt = sidx_r + 2'd1;
        if (sidx_r == 2'd3) begin
          num_nxt  = NW'(SRC_SIZE);
          rem_nxt  = '0;
          dcnt_nxt = '0;
          state_nxt = S_DIV_COL;
        end
      end
      S_DIV_COL: begin
        if (div_last) begin
          q_nxt    = CW'(div_quo);
          r_nxt    = div_rem;
          sidx_nxt = '0;
          on_nxt   = '0;
          x_nxt    = '0;
          state_nxt = S_COLS;
        end
      end
      S_COLS: begin
        if (sidx_r == 2'd2) begin
          sidx_nxt = '0;
          on_nxt   = '0;
          if (on_tot >= thr_r) begin
            mask_nxt = mask_r | (MAX_DRAW'(1) << x_r);
          end
          if (x_r == d_r - DW'(1)) begin
            state_nxt = S_DONE;
          end else begin
            x_nxt = x_r + DW'(1);
          end
        end else begin
          on_nxt   = on_tot;
          sidx_nxt = sidx_r + 2'd1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{PAD_W{1'b0}}, MASK_W'(mask_r), origin_x_r,
                           SCREEN_ROW_W'({origin_y_r[COORD_W-1], origin_y_r})
                           + SCREEN_ROW_W'(y_r)};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      draw_size_r <= DRAW_RESET;
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      draw_size_r <= draw_size_nxt;
      origin_x_r  <= origin_x_nxt;
      origin_y_r  <= origin_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r        <= d_nxt;
    dv_r       <= dv_nxt;
    thr_r      <= thr_nxt;
    y_r        <= y_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    dcnt_r     <= dcnt_nxt;
    q_r        <= q_nxt;
    r_r        <= r_nxt;
    qs_r       <= qs_nxt;
    rs_r       <= rs_nxt;
    sidx_r     <= sidx_nxt;
    on_r       <= on_nxt;
    x_r        <= x_nxt;
    mask_r     <= mask_nxt;
    rows_r     <= rows_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COLS) |-> (x_r < d_r && sidx_r <= 2'd2))
    else $error("column walk past draw size");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_STEP || state_r == S_DIV_ROW || state_r == S_DIV_COL)
      |-> (dcnt_r <= KW'(NW - 1)))
    else $error("divider count overrun");

  a_done_from_cols: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && $past(state_r) != S_DONE) |-> ($past(state_r) == S_COLS))
    else $error("result raised without column pass");

  a_row_before_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_COL && $past(state_r) != S_DIV_COL) |-> ($past(state_r) == S_ROWS))
    else $error("column divide started without row fetch");

endmodule
